>>> rtl/core/md5de_pkg.sv
// Shared types, constants and tables for the MD5 digest engine.
// The controller, the datapath and the top level all import this package.
`default_nettype none

package md5de_pkg;

  // Initial chaining words.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Number of compression steps in one block, minus one.
  localparam logic [5:0] LAST_STEP = 6'd63;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       append;     // write the accepted beat's bytes into the buffer
    logic       init_abcd;  // load the working words from the chaining value
    logic       step;       // run one compression step
    logic [5:0] step_idx;   // index of that step
    logic       add_chain;  // fold the working words into the chaining value
    logic       data_blk;   // the block just compressed held message data only
    logic       pad;        // write the 0x80 marker, zero fill and maybe the length
    logic       len_clear;  // clear the buffer and write the length
    logic       emit;       // capture the digest and start a new message
  } md5de_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic overflow;   // the offered beat fills the block
    logic fill_ge56;  // no room for the length after the marker
  } md5de_stat_t;

  // Additive step constants.
  function automatic logic [31:0] md5de_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amounts, indexed by round and the low two bits of the step.
  function automatic logic [4:0] md5de_rot(input logic [3:0] sel);
    logic [4:0] s;
    unique case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word selected by each step.
  function automatic logic [3:0] md5de_g(input logic [5:0] idx);
    logic [3:0] ix;
    logic [3:0] g;
    ix = idx[3:0];
    case (idx[5:4])
      2'd0:    g = ix;
      2'd1:    g = 4'((ix * 4'd5) + 4'd1);
      2'd2:    g = 4'((ix * 4'd3) + 4'd5);
      default: g = 4'(ix * 4'd7);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/md5de_ctrl.sv
// Controller of the MD5 digest engine: sequences gathering, compression,
// padding and digest output. Uses md5de_pkg for the command and status types.
`default_nettype none

module md5de_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  input  wire                      in_last_item,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire                      out_stall,
  input  md5de_pkg::md5de_stat_t   stat,
  output md5de_pkg::md5de_cmd_t    cmd
);
  import md5de_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COMP = 6'b000010,
    S_ADD  = 6'b000100,
    S_PAD  = 6'b001000,
    S_LEN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  // Purpose of the block under compression.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_FINAL = 2'd2
  } kind_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  logic [5:0] step_r, step_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.step_idx = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.append = 1'b1;
          if (stat.overflow) begin
            cmd.init_abcd = 1'b1;
            kind_nxt  = KIND_DATA;
            last_nxt  = in_last_item;
            state_nxt = S_COMP;
          end else if (in_last_item) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_COMP: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        cmd.data_blk  = (kind_r == KIND_DATA);
        unique case (kind_r)
          KIND_DATA: state_nxt = last_r ? S_PAD : S_IDLE;
          KIND_PAD:  state_nxt = S_LEN;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_PAD: begin
        cmd.pad       = 1'b1;
        cmd.init_abcd = 1'b1;
        kind_nxt  = stat.fill_ge56 ? KIND_PAD : KIND_FINAL;
        state_nxt = S_COMP;
      end
      S_LEN: begin
        cmd.len_clear = 1'b1;
        cmd.init_abcd = 1'b1;
        kind_nxt  = KIND_FINAL;
        state_nxt = S_COMP;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          last_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output beat stays until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_DATA;
      step_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // The fold into the chaining value follows exactly the last of the steps.
  a_add_after_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> $past(state_r) == S_COMP && $past(step_r) == LAST_STEP)
    else $error("chain fold without a full set of steps");

  // Every compression begins from freshly loaded working words.
  a_comp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMP && step_r == 6'd0 |-> $past(cmd.init_abcd))
    else $error("compression started without loading working words");

  // A digest is only produced after the length block.
  a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> kind_r == KIND_FINAL)
    else $error("digest output before the final block");

  // A new output beat only comes from the output state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("output beat raised outside the output state");

endmodule

`default_nettype wire

>>> rtl/core/md5de_dp.sv
// Datapath of the MD5 digest engine: block buffer, byte gathering, padding,
// one-step-per-cycle compression and the chaining value. Uses md5de_pkg.
`default_nettype none

module md5de_dp (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  [31:0]              in_msg_word,
  input  wire  [2:0]               in_valid_bytes,
  input  md5de_pkg::md5de_cmd_t    cmd,
  output md5de_pkg::md5de_stat_t   stat,
  output logic [63:0]              out_digest_low,
  output logic [63:0]              out_digest_high
);
  import md5de_pkg::*;

  logic [31:0] buf_r [16];
  logic [31:0] buf_nxt [16];
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [54:0] blocks_r, blocks_nxt;
  logic [23:0] pend_word_r, pend_word_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [63:0] dig_low_r, dig_high_r;

  logic [2:0]  cnt_sat;
  logic [6:0]  fill_sum;
  logic [6:0]  consumed;
  logic [5:0]  wr_start;
  logic [31:0] wr_word;
  logic [2:0]  wr_cnt;
  logic        wr_en;
  logic [63:0] bit_len;
  logic [6:0]  pos;

  logic [31:0] f_val;
  logic [31:0] step_sum;
  logic [63:0] rot_w;
  logic [4:0]  rot_s;

  // Byte count of the offered beat, with oversized counts taken as four.
  assign cnt_sat  = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign fill_sum = {1'b0, fill_r} + {4'd0, cnt_sat};
  assign consumed = 7'd64 - {1'b0, fill_r};

  assign stat.overflow  = (fill_sum >= 7'd64);
  assign stat.fill_ge56 = (fill_r >= 6'd56);

  // Message length in bits: whole blocks, then buffered bytes.
  assign bit_len = {blocks_r, fill_r, 3'b000};

  // Byte writer source: the accepted beat, or bytes left over after a full block.
  assign wr_en    = cmd.append || (cmd.add_chain && cmd.data_blk);
  assign wr_start = cmd.append ? fill_r : 6'd0;
  assign wr_word  = cmd.append ? in_msg_word : {8'd0, pend_word_r};
  assign wr_cnt   = cmd.append ? cnt_sat : {1'b0, pend_cnt_r};

  // Block buffer update: gathering, padding and length.
  always_comb begin
    pos = '0;
    for (int w = 0; w < 16; w++) begin
      buf_nxt[w] = buf_r[w];
    end
    if (wr_en) begin
      for (int k = 0; k < 4; k++) begin
        pos = {1'b0, wr_start} + 7'(k);
        if ((3'(k) < wr_cnt) && (pos < 7'd64)) begin
          buf_nxt[pos[5:2]][{pos[1:0], 3'b000} +: 8] = wr_word[8*k +: 8];
        end
      end
    end
    if (cmd.pad) begin
      for (int p = 0; p < 64; p++) begin
        if (6'(p) == fill_r) begin
          buf_nxt[p / 4][8 * (p % 4) +: 8] = 8'h80;
        end else if (6'(p) > fill_r) begin
          buf_nxt[p / 4][8 * (p % 4) +: 8] = 8'h00;
        end
      end
      if (!stat.fill_ge56) begin
        buf_nxt[14] = bit_len[31:0];
        buf_nxt[15] = bit_len[63:32];
      end
    end
    if (cmd.len_clear) begin
      for (int w = 0; w < 14; w++) begin
        buf_nxt[w] = '0;
      end
      buf_nxt[14] = bit_len[31:0];
      buf_nxt[15] = bit_len[63:32];
    end
  end

  // Round function of the current step.
  always_comb begin
    case (cmd.step_idx[5:4])
      2'd0:    f_val = d_r ^ (b_r & (c_r ^ d_r));
      2'd1:    f_val = c_r ^ (d_r & (b_r ^ c_r));
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  // One compression step: add, rotate, add.
  assign step_sum = a_r + f_val + md5de_k(cmd.step_idx)
                    + buf_r[md5de_g(cmd.step_idx)];
  assign rot_s    = md5de_rot({cmd.step_idx[5:4], cmd.step_idx[1:0]});
  assign rot_w    = {step_sum, step_sum} << rot_s;

  // Working words and chaining value.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    for (int i = 0; i < 4; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    if (cmd.init_abcd) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
    end else if (cmd.step) begin
      a_nxt = d_r;
      d_nxt = c_r;
      c_nxt = b_r;
      b_nxt = b_r + rot_w[63:32];
    end
    if (cmd.add_chain) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
    end
    if (cmd.emit) begin
      chain_nxt[0] = IV_A;
      chain_nxt[1] = IV_B;
      chain_nxt[2] = IV_C;
      chain_nxt[3] = IV_D;
    end
  end

  // Fill level, block count and bytes left over from a beat that spans blocks.
  always_comb begin
    fill_nxt      = fill_r;
    blocks_nxt    = blocks_r;
    pend_word_nxt = pend_word_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (cmd.append) begin
      if (stat.overflow) begin
        pend_word_nxt = 24'(in_msg_word >> {consumed[2:0], 3'b000});
        pend_cnt_nxt  = 2'(fill_sum - 7'd64);
      end else begin
        fill_nxt = fill_sum[5:0];
      end
    end
    if (cmd.add_chain && cmd.data_blk) begin
      fill_nxt   = {4'd0, pend_cnt_r};
      blocks_nxt = blocks_r + 55'd1;
    end
    if (cmd.emit) begin
      fill_nxt   = '0;
      blocks_nxt = '0;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
      fill_r     <= '0;
      blocks_r   <= '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
      fill_r   <= fill_nxt;
      blocks_r <= blocks_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      buf_r[w] <= buf_nxt[w];
    end
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    c_r         <= c_nxt;
    d_r         <= d_nxt;
    pend_word_r <= pend_word_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    if (cmd.emit) begin
      dig_low_r  <= {chain_r[1], chain_r[0]};
      dig_high_r <= {chain_r[3], chain_r[2]};
    end
  end

  assign out_digest_low  = dig_low_r;
  assign out_digest_high = dig_high_r;

endmodule

`default_nettype wire

>>> rtl/core/md5_digest_engine_unit.sv
// Top level of the MD5 digest engine: joins the controller and the datapath.
// Depends on md5de_pkg, md5de_ctrl and md5de_dp.
//
//   Channel  Direction  Beat contents
//   in_      input      msg_word, valid_bytes, last_item
//   out_     output     digest_low, digest_high (one beat per message)
//
// A full 64-byte block is gathered from accepted beats, run through the single
// MD5 step unit and folded into the chaining value. A last beat adds a padding
// step and an output step, plus one or two final blocks. Reset is synchronous;
// no clearing pass is needed. in_stall is high from a beat that fills a block
// or ends a message until the controller is idle again; a waiting output beat
// does not block input until the next digest is ready.
`default_nettype none

module md5_digest_engine_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_msg_word,
  input  wire  [2:0]  in_valid_bytes,
  input  wire         in_last_item,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);
  import md5de_pkg::*;

  md5de_cmd_t  cmd;
  md5de_stat_t stat;

  md5de_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  md5de_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_msg_word     (in_msg_word),
    .in_valid_bytes  (in_valid_bytes),
    .cmd             (cmd),
    .stat            (stat),
    .out_digest_low  (out_digest_low),
    .out_digest_high (out_digest_high)
  );

endmodule

`default_nettype wire
